[rtl/core/kfl_pkg.sv]
// Shared types and constants for the keypad and fingerprint lock controller.
// Holds event codes, key codes, mode enum, result codes and transaction structs.
// No dependencies.
`default_nettype none

package kfl_pkg;

   // Field widths
   localparam int SYM_W    = 4;
   localparam int PIN_SYMS = 9;
   localparam int CODE_W   = SYM_W * PIN_SYMS;
   localparam int COUNT_W  = 4;
   localparam int ID_W     = 16;
   localparam int LIMIT_W  = 3;

   // Event sources
   typedef enum logic [2:0] {
      FUNC_KEY         = 3'd0,
      FUNC_FINGER_OK   = 3'd1,
      FUNC_FINGER_FAIL = 3'd2,
      FUNC_REMOTE      = 3'd3,
      FUNC_ENROLL      = 3'd4,
      FUNC_DELETE      = 3'd5,
      FUNC_CHANGE_PIN  = 3'd6,
      FUNC_AUTOLOCK    = 3'd7
   } func_type;

   // Controller mode
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FINGER = 2'd1,
      MODE_PIN    = 2'd2
   } mode_type;

   // Keypad symbols with a control meaning
   localparam logic [SYM_W-1:0] KEY_A    = 4'd10;
   localparam logic [SYM_W-1:0] KEY_B    = 4'd11;
   localparam logic [SYM_W-1:0] KEY_C    = 4'd12;
   localparam logic [SYM_W-1:0] KEY_D    = 4'd13;
   localparam logic [SYM_W-1:0] KEY_STAR = 4'd14;

   // Result codes
   localparam logic [1:0] REPORT_NONE   = 2'd0;
   localparam logic [1:0] REPORT_FINGER = 2'd1;
   localparam logic [1:0] REPORT_PIN    = 2'd2;
   localparam logic [1:0] ALARM_NONE    = 2'd0;
   localparam logic [1:0] ALARM_SHORT   = 2'd1;
   localparam logic [1:0] ALARM_LONG    = 2'd2;
   localparam logic [1:0] SENSOR_NONE   = 2'd0;
   localparam logic [1:0] SENSOR_ENROLL = 2'd1;
   localparam logic [1:0] SENSOR_DELETE = 2'd2;

   // Reset values
   localparam logic [CODE_W-1:0]  RESET_CODE       = 36'h0_0000_4321;
   localparam logic [COUNT_W-1:0] RESET_LEN        = 4'd4;
   localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RESET = 3'd3;

   // Register map
   localparam logic REG_FAIL_LIMIT = 1'b0;

   // One input transaction
   typedef struct packed {
      func_type             func;
      logic [SYM_W-1:0]     key_code;
      logic [ID_W-1:0]      ident;
      logic [CODE_W-1:0]    new_pin;
      logic [COUNT_W-1:0]   new_pin_len;
   } req_item_type;

   // One result transaction
   typedef struct packed {
      logic                 unlock;
      logic [1:0]           report_kind;
      logic [ID_W-1:0]      report_id;
      logic [1:0]           alarm;
      logic                 relock;
      logic [1:0]           sensor_cmd;
      logic [ID_W-1:0]      sensor_id;
      mode_type             mode_now;
      logic [COUNT_W-1:0]   entered_count;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/core/keypad_fingerprint_lock_controller_core.sv]
// Keypad and fingerprint lock controller: top level with event register,
// single-pass event logic and result register. Depends on kfl_pkg, kfl_pin_cmp.
//
// Usage:
//   req_* carries one lock event per transaction (valid/ready). rsp_* returns
//   exactly one result transaction per event, in order (valid/ready).
//   The APB-style port holds fail_limit at byte address 0; write it only
//   while no event is in flight. pready is tied high.
// Timing: the accepting edge loads the event register; the result register is
//   loaded when the event fires, which needs the result slot free or being
//   drained; the state update happens on the edge that loads the result
//   register.
// Throughput: one event per cycle unless rsp_ready stalls, set by the event
//   logic that reads and writes state, including the nine-symbol compare.
// Reset (synchronous, active high): both stages empty, mode idle, nothing
//   typed, stored PIN 1234, failure count 0, fail_limit 3. Typed symbols are
//   not cleared; only positions already typed are ever compared.
// Stall: while rsp_ready is low the result register holds; one further event
//   is still taken into the event register, after which req_ready drops.
`default_nettype none

module keypad_fingerprint_lock_controller_core import kfl_pkg::*; #(
   parameter int PIN_MAX = 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // event channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_func,
   input  wire logic [3:0]         req_key_code,
   input  wire logic [15:0]        req_ident,
   input  wire logic [35:0]        req_new_pin,
   input  wire logic [3:0]         req_new_pin_len,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_unlock,
   output logic [1:0]              rsp_report_kind,
   output logic [15:0]             rsp_report_id,
   output logic [1:0]              rsp_alarm,
   output logic                    rsp_relock,
   output logic [1:0]              rsp_sensor_cmd,
   output logic [15:0]             rsp_sensor_id,
   output logic [1:0]              rsp_mode_now,
   output logic [3:0]              rsp_entered_count,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int TypeCap = (PIN_MAX > 15) ? 15 : PIN_MAX;
   localparam int IdxW    = (TypeCap > 1) ? $clog2(TypeCap) : 1;

   // Pipeline registers
   logic          evt_valid_ff;
   req_item_type  evt_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;
   rsp_item_type  rsp_in;

   // Controller state
   mode_type             mode_ff, mode_in;
   logic [COUNT_W-1:0]   typed_count_ff, typed_count_in;
   logic [SYM_W-1:0]     typed_sym_ff [TypeCap];
   logic [CODE_W-1:0]    stored_code_ff, stored_code_in;
   logic [COUNT_W-1:0]   stored_len_ff, stored_len_in;
   logic [LIMIT_W-1:0]   fail_count_ff, fail_count_in;
   logic [LIMIT_W-1:0]   fail_limit_ff;

   logic                 advance;
   logic                 fire;
   logic                 pin_match;
   logic                 do_unlock;
   logic                 do_append;
   logic [LIMIT_W-1:0]   fail_next;

   // Handshake: the event stage moves on whenever the result slot is free
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = evt_valid_ff && advance;
   assign req_ready = !evt_valid_ff || advance;

   // Hold the accepted transaction in the event register
   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (req_ready) begin
         evt_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         evt_ff.func        <= func_type'(req_func);
         evt_ff.key_code    <= req_key_code;
         evt_ff.ident       <= req_ident;
         evt_ff.new_pin     <= req_new_pin;
         evt_ff.new_pin_len <= req_new_pin_len;
      end
   end

   kfl_pin_cmp #(
      .TYPE_CAP (TypeCap)
   ) u_pin_cmp (
      .typed_sym   (typed_sym_ff),
      .typed_count (typed_count_ff),
      .stored_code (stored_code_ff),
      .stored_len  (stored_len_ff),
      .match       (pin_match)
   );

   // Failure count after one more failure, wrapping at three bits
   assign fail_next = fail_count_ff + LIMIT_W'(1);

   // Result fields and datapath state for the event in the event register
   always_comb begin
      rsp_in             = '0;
      rsp_in.mode_now    = MODE_IDLE;
      typed_count_in     = typed_count_ff;
      stored_code_in     = stored_code_ff;
      stored_len_in      = stored_len_ff;
      fail_count_in      = fail_count_ff;
      do_unlock          = 1'b0;
      do_append          = 1'b0;
      case (evt_ff.func)
         FUNC_AUTOLOCK: begin
            rsp_in.relock = 1'b1;
         end
         FUNC_ENROLL, FUNC_DELETE: begin
            rsp_in.sensor_cmd = (evt_ff.func == FUNC_ENROLL) ? SENSOR_ENROLL : SENSOR_DELETE;
            rsp_in.sensor_id  = evt_ff.ident;
         end
         FUNC_CHANGE_PIN: begin
            stored_code_in = evt_ff.new_pin;
            stored_len_in  = (evt_ff.new_pin_len > COUNT_W'(PIN_SYMS)) ?
                             COUNT_W'(PIN_SYMS) : evt_ff.new_pin_len;
         end
         FUNC_REMOTE: begin
            do_unlock = 1'b1;
         end
         default: begin
            case (mode_ff)
               MODE_IDLE: begin
                  if (evt_ff.func == FUNC_KEY &&
                      (evt_ff.key_code == KEY_A || evt_ff.key_code == KEY_B)) begin
                     typed_count_in = '0;
                  end
               end
               MODE_FINGER: begin
                  if (evt_ff.func == FUNC_FINGER_OK && evt_ff.ident != '0) begin
                     do_unlock          = 1'b1;
                     rsp_in.report_kind = REPORT_FINGER;
                     rsp_in.report_id   = evt_ff.ident;
                  end else if (evt_ff.func == FUNC_FINGER_FAIL) begin
                     if (fail_next >= fail_limit_ff) begin
                        rsp_in.alarm  = ALARM_LONG;
                        fail_count_in = '0;
                     end else begin
                        rsp_in.alarm  = ALARM_SHORT;
                        fail_count_in = fail_next;
                     end
                  end
               end
               MODE_PIN: begin
                  if (evt_ff.func == FUNC_KEY) begin
                     if (evt_ff.key_code == KEY_STAR || evt_ff.key_code == KEY_C) begin
                        typed_count_in = '0;
                     end else if (evt_ff.key_code == KEY_D) begin
                        typed_count_in = '0;
                        if (pin_match) begin
                           do_unlock          = 1'b1;
                           rsp_in.report_kind = REPORT_PIN;
                        end else if (fail_next >= fail_limit_ff) begin
                           rsp_in.alarm  = ALARM_LONG;
                           fail_count_in = '0;
                        end else begin
                           rsp_in.alarm  = ALARM_SHORT;
                           fail_count_in = fail_next;
                        end
                     end else if (typed_count_ff < COUNT_W'(TypeCap)) begin
                        do_append      = 1'b1;
                        typed_count_in = typed_count_ff + COUNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      endcase
      if (do_unlock) begin
         rsp_in.unlock = 1'b1;
         fail_count_in = '0;
      end
      rsp_in.mode_now      = mode_in;
      rsp_in.entered_count = typed_count_in;
   end

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      case (evt_ff.func)
         FUNC_AUTOLOCK: begin
            mode_in = mode_ff;
         end
         FUNC_ENROLL, FUNC_DELETE, FUNC_CHANGE_PIN, FUNC_REMOTE: begin
            mode_in = MODE_IDLE;
         end
         default: begin
            case (mode_ff)
               MODE_IDLE: begin
                  if (evt_ff.func == FUNC_KEY && evt_ff.key_code == KEY_A) begin
                     mode_in = MODE_FINGER;
                  end else if (evt_ff.func == FUNC_KEY && evt_ff.key_code == KEY_B) begin
                     mode_in = MODE_PIN;
                  end
               end
               MODE_FINGER, MODE_PIN: begin
                  if (evt_ff.func == FUNC_KEY && evt_ff.key_code == KEY_STAR) begin
                     mode_in = MODE_IDLE;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
            if (do_unlock) begin
               mode_in = MODE_IDLE;
            end
         end
      endcase
   end

   // Update state and load the result register when the event fires
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_IDLE;
         typed_count_ff <= '0;
         stored_code_ff <= RESET_CODE;
         stored_len_ff  <= RESET_LEN;
         fail_count_ff  <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= evt_valid_ff;
         end
         if (fire) begin
            mode_ff        <= mode_in;
            typed_count_ff <= typed_count_in;
            stored_code_ff <= stored_code_in;
            stored_len_ff  <= stored_len_in;
            fail_count_ff  <= fail_count_in;
         end
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Append a typed symbol at the current count
   always_ff @(posedge clock) begin
      if (fire && do_append) begin
         typed_sym_ff[typed_count_ff[IdxW-1:0]] <= evt_ff.key_code;
      end
   end

   // Register port: write the failure limit, read it back
   always_ff @(posedge clock) begin
      if (reset) begin
         fail_limit_ff <= FAIL_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAIL_LIMIT) begin
         fail_limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_FAIL_LIMIT) ? {29'd0, fail_limit_ff} : 32'd0;

   // Drive the result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unlock        = rsp_ff.unlock;
   assign rsp_report_kind   = rsp_ff.report_kind;
   assign rsp_report_id     = rsp_ff.report_id;
   assign rsp_alarm         = rsp_ff.alarm;
   assign rsp_relock        = rsp_ff.relock;
   assign rsp_sensor_cmd    = rsp_ff.sensor_cmd;
   assign rsp_sensor_id     = rsp_ff.sensor_id;
   assign rsp_mode_now      = rsp_ff.mode_now;
   assign rsp_entered_count = rsp_ff.entered_count;

endmodule

`default_nettype wire

[rtl/core/kfl_pin_cmp.sv]
// PIN comparator: checks the typed symbols against the stored PIN.
// Depends on kfl_pkg for symbol and code widths.
`default_nettype none

module kfl_pin_cmp import kfl_pkg::*; #(
   parameter int TYPE_CAP = 9
) (
   input  wire logic [SYM_W-1:0]   typed_sym [TYPE_CAP],
   input  wire logic [COUNT_W-1:0] typed_count,
   input  wire logic [CODE_W-1:0]  stored_code,
   input  wire logic [COUNT_W-1:0] stored_len,
   output logic                    match
);

   localparam int CmpSyms = (TYPE_CAP < PIN_SYMS) ? TYPE_CAP : PIN_SYMS;

   logic [CmpSyms-1:0] sym_ok;

   // Compare each position; positions past the stored length always pass
   always_comb begin
      for (int i = 0; i < CmpSyms; i++) begin
         sym_ok[i] = (COUNT_W'(i) >= stored_len) ||
                     (stored_code[i*SYM_W +: SYM_W] == typed_sym[i]);
      end
   end

   // Lengths must agree as well
   assign match = (typed_count == stored_len) && (&sym_ok);

endmodule

`default_nettype wire

[rtl/core/kfl_checker.sv]
// Port-level checks for the lock controller, bound to the top level.
// Depends on kfl_pkg for result codes and on the top-level port list.
`default_nettype none

module kfl_checker import kfl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_unlock,
   input wire logic [1:0]  rsp_report_kind,
   input wire logic [15:0] rsp_report_id,
   input wire logic [1:0]  rsp_alarm,
   input wire logic        rsp_relock,
   input wire logic [1:0]  rsp_mode_now
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unlock) &&
      $stable(rsp_alarm) && $stable(rsp_mode_now))
      else $error("result changed while stalled");

   // An opening always leaves the controller idle
   a_unlock_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unlock |-> rsp_mode_now == MODE_IDLE)
      else $error("unlock without return to idle");

   // A report or an id only comes with an opening
   a_report_unlock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_report_kind != REPORT_NONE || rsp_report_id != '0) |-> rsp_unlock)
      else $error("report without unlock");

   // One event never both opens and raises an alarm or closes
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unlock |-> rsp_alarm == ALARM_NONE && !rsp_relock)
      else $error("unlock combined with alarm or close");

   // Nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind keypad_fingerprint_lock_controller_core kfl_checker u_kfl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_unlock      (rsp_unlock),
   .rsp_report_kind (rsp_report_kind),
   .rsp_report_id   (rsp_report_id),
   .rsp_alarm       (rsp_alarm),
   .rsp_relock      (rsp_relock),
   .rsp_mode_now    (rsp_mode_now)
);

`default_nettype wire
